// ===== rtl/plal_pkg.sv =====
// ----------------------------------------------------------------------------
// plal_pkg
// Shared types and codes for the positional array list: request codes,
// status codes, field widths and the command that goes to every cell.
// ----------------------------------------------------------------------------
package plal_pkg;

   // field widths
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   // default list depth
   localparam int DEFAULT_CAPACITY = 128;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RM_LAST = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RM_AT   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // broadcast command for the row of cells
   typedef struct packed {
      logic ins_en;      // open a gap at op position and drop the item in
      logic del_en;      // close the gap at op position
      logic load_scan;   // copy every entry into its scan register
      logic shift_scan;  // move the scan chain one cell toward cell zero
   } cell_cmd_type;

endpackage

// ===== rtl/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded ordered list of signed words kept in a row of cells, one entry per
// cell, with a fill count. Insert and remove at position shift all cells from the op position upward at once;
// reads go out through a scan chain that moves toward cell zero.
// ----------------------------------------------------------------------------
// response: insert, append and any error give rsp_valid in the cycle after accept
// response: read, remove last and remove at position give rsp_valid once the scan
//   chain has moved the entry at the position read down to cell zero
// throughput: one request at a time; the next is taken the cycle after the
//   response beat is taken
// reset: list empty (fill zero), idle, no response pending; entries undefined
module positional_array_list_unit #(
   parameter int CAPACITY = plal_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [plal_pkg::FUNC_W-1:0]         req_func,
   input  logic [plal_pkg::POS_W-1:0]          req_pos,
   input  logic signed [plal_pkg::DATA_W-1:0]  req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [plal_pkg::DATA_W-1:0]  rsp_data,
   output logic [plal_pkg::STATUS_W-1:0]       rsp_status,
   output logic [plal_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > plal_pkg::POS_W) ? FILL_W : plal_pkg::POS_W;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

   // state codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [FILL_W-1:0]                   fill_ff, fill_in;
   logic [IDX_W-1:0]                    cnt_ff, cnt_in;
   logic signed [plal_pkg::DATA_W-1:0]  data_ff, data_in;
   logic [plal_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [plal_pkg::COUNT_W-1:0]        count_ff, count_in;

   logic                                req_fire;
   logic                                scan_needed;
   logic [IDX_W-1:0]                    scan_idx;
   logic [IDX_W-1:0]                    op_pos;
   logic                                ins_req, del_req;
   logic [plal_pkg::STATUS_W-1:0]       dec_status;
   logic signed [plal_pkg::DATA_W-1:0]  dec_data;
   logic [FILL_W-1:0]                   dec_fill;
   logic [CMP_W-1:0]                    pos_x, fill_x;
   plal_pkg::cell_cmd_type              cmd;

   logic signed [plal_pkg::DATA_W-1:0]  entry_w [CAPACITY];
   logic signed [plal_pkg::DATA_W-1:0]  scan_w  [CAPACITY];

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign pos_x     = CMP_W'(req_pos);
   assign fill_x    = CMP_W'(fill_ff);

   // request decode against the current fill
   always_comb begin
      dec_status  = plal_pkg::ST_OK;
      dec_data    = '0;
      dec_fill    = fill_ff;
      scan_needed = 1'b0;
      scan_idx    = '0;
      op_pos      = '0;
      ins_req     = 1'b0;
      del_req     = 1'b0;
      unique case (req_func)
         plal_pkg::FUNC_READ: begin
            if (pos_x < fill_x) begin
               scan_needed = 1'b1;
               scan_idx    = IDX_W'(req_pos);
            end else begin
               dec_status = plal_pkg::ST_BADPOS;
            end
         end
         plal_pkg::FUNC_INSERT: begin
            if (fill_ff >= FILL_MAX) begin
               dec_status = plal_pkg::ST_FULL;
            end else if (pos_x > fill_x) begin
               dec_status = plal_pkg::ST_BADPOS;
            end else begin
               ins_req  = 1'b1;
               op_pos   = IDX_W'(req_pos);
               dec_fill = fill_ff + 1'b1;
            end
         end
         plal_pkg::FUNC_APPEND: begin
            if (fill_ff >= FILL_MAX) begin
               dec_status = plal_pkg::ST_FULL;
            end else begin
               ins_req  = 1'b1;
               op_pos   = IDX_W'(fill_ff);
               dec_fill = fill_ff + 1'b1;
            end
         end
         plal_pkg::FUNC_RM_LAST: begin
            if (fill_ff == '0) begin
               dec_status = plal_pkg::ST_EMPTY;
               dec_data   = '1;
            end else begin
               dec_fill    = fill_ff - 1'b1;
               scan_needed = 1'b1;
               scan_idx    = IDX_W'(dec_fill);
            end
         end
         plal_pkg::FUNC_RM_AT: begin
            if (fill_ff == '0) begin
               dec_status = plal_pkg::ST_EMPTY;
            end else if (pos_x >= fill_x) begin
               dec_status = plal_pkg::ST_BADPOS;
            end else begin
               del_req     = 1'b1;
               op_pos      = IDX_W'(req_pos);
               dec_fill    = fill_ff - 1'b1;
               scan_needed = 1'b1;
               scan_idx    = IDX_W'(req_pos);
            end
         end
         default: begin
         end
      endcase
   end

   // broadcast command for the cells
   always_comb begin
      cmd.ins_en     = req_fire & ins_req;
      cmd.del_en     = req_fire & del_req;
      cmd.load_scan  = req_fire & scan_needed;
      cmd.shift_scan = (state_ff == S_SCAN) && (cnt_ff != '0);
   end

   // control sequence and response register
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      status_in = status_ff;
      count_in  = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               fill_in   = dec_fill;
               data_in   = dec_data;
               status_in = dec_status;
               count_in  = plal_pkg::COUNT_W'(dec_fill);
               cnt_in    = scan_idx;
               state_in  = scan_needed ? S_SCAN : S_RESP;
            end
         end
         S_SCAN: begin
            if (cnt_ff == '0) begin
               data_in  = scan_w[0];
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
      end
      data_ff   <= data_in;
      status_ff <= status_in;
      count_ff  <= count_in;
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [plal_pkg::DATA_W-1:0] below_w, above_w, scan_above_w;

      if (i == 0) begin : g_first
         assign below_w = '0;
      end else begin : g_mid_lo
         assign below_w = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign above_w      = '0;
         assign scan_above_w = '0;
      end else begin : g_mid_hi
         assign above_w      = entry_w[i+1];
         assign scan_above_w = scan_w[i+1];
      end

      plal_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .op_pos      (op_pos),
         .item        (req_item),
         .entry_below (below_w),
         .entry_above (above_w),
         .scan_above  (scan_above_w),
         .entry       (entry_w[i]),
         .scan        (scan_w[i])
      );
   end

   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_data   = data_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;

   // fill never passes the capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill above capacity");

   // fill moves only on an accepted beat
   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(req_fire)) |-> $stable(fill_ff))
      else $error("fill changed without a request beat");

   // a scan in flight keeps scanning until the counter runs out
   a_scan_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cnt_ff != '0) |=> (state_ff == S_SCAN))
      else $error("scan left early");

   // no new request while a response is pending
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken with a response pending");

endmodule

// ===== rtl/plal_cell.sv =====
// ----------------------------------------------------------------------------
// plal_cell
// One list slot. Holds one entry and one scan register. Shifts up on an
// insert above the op position, down on a delete at or above it, and passes
// its scan value to the neighbor below while a scan is in flight.
// ----------------------------------------------------------------------------
module plal_cell #(
   parameter int IDX_W = 7,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  plal_pkg::cell_cmd_type            cmd,
   input  logic [IDX_W-1:0]                  op_pos,
   input  logic signed [plal_pkg::DATA_W-1:0] item,
   input  logic signed [plal_pkg::DATA_W-1:0] entry_below,
   input  logic signed [plal_pkg::DATA_W-1:0] entry_above,
   input  logic signed [plal_pkg::DATA_W-1:0] scan_above,
   output logic signed [plal_pkg::DATA_W-1:0] entry,
   output logic signed [plal_pkg::DATA_W-1:0] scan
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [plal_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic signed [plal_pkg::DATA_W-1:0] scan_ff, scan_in;

   // entry update for insert and delete
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en) begin
         if (MY_IDX == op_pos) begin
            entry_in = item;
         end else if (MY_IDX > op_pos) begin
            entry_in = entry_below;
         end
      end else if (cmd.del_en) begin
         if (MY_IDX >= op_pos) begin
            entry_in = entry_above;
         end
      end
   end

   // scan chain toward cell zero
   always_comb begin
      scan_in = scan_ff;
      if (cmd.load_scan) begin
         scan_in = entry_ff;
      end else if (cmd.shift_scan) begin
         scan_in = scan_above;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      scan_ff  <= scan_in;
   end

   assign entry = entry_ff;
   assign scan  = scan_ff;

endmodule
